@@ rtl/tss_pkg.sv @@
// Shared request codes, LED levels, field widths and control types for the step sequencer.
package tss_pkg;

   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 24;

   localparam int COL_W     = 4;
   localparam int ROW_IDX_W = 3;
   localparam int LED_W     = 4;
   localparam int TRIG_W    = 8;
   localparam int POS_W     = 4;

   localparam logic [REQ_TUSER_W-1:0] REQ_RISE    = 3'd0;
   localparam logic [REQ_TUSER_W-1:0] REQ_FALL    = 3'd1;
   localparam logic [REQ_TUSER_W-1:0] REQ_KEY     = 3'd2;
   localparam logic [REQ_TUSER_W-1:0] REQ_STOP    = 3'd3;
   localparam logic [REQ_TUSER_W-1:0] REQ_LED     = 3'd4;
   localparam logic [REQ_TUSER_W-1:0] REQ_CLEAR   = 3'd5;
   localparam logic [REQ_TUSER_W-1:0] REQ_REFRESH = 3'd6;

   localparam logic [LED_W-1:0] LED_OFF             = 4'd0;
   localparam logic [LED_W-1:0] LED_CHECKER         = 4'd2;
   localparam logic [LED_W-1:0] LED_POSITION        = 4'd6;
   localparam logic [LED_W-1:0] LED_ACTIVE          = 4'd10;
   localparam logic [LED_W-1:0] LED_ACTIVE_POSITION = 4'd15;

   // pattern memory command for one cycle
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr;
   } tss_mem_ctl_type;

endpackage

@@ rtl/tss_pattern_mem.sv @@
// Pattern column memory: synchronous read, write-after-read bypass, per-column valid bits.
module tss_pattern_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   parameter int AW    = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tss_pkg::tss_mem_ctl_type ctl,
   input  logic [AW-1:0]            rd_addr,
   input  logic [AW-1:0]            wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_q_ff;
   logic [AW-1:0]    raddr_ff;
   logic [DEPTH-1:0] valid_ff;
   logic             byp_vld_ff;
   logic [AW-1:0]    byp_addr_ff;
   logic [WIDTH-1:0] byp_data_ff;
   logic             byp_hit;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff     <= mem[rd_addr];
         raddr_ff    <= rd_addr;
         byp_addr_ff <= wr_addr;
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         byp_vld_ff <= 1'b0;
      end else begin
         if (ctl.clr) begin
            valid_ff <= '0;
         end else if (ctl.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            byp_vld_ff <= ctl.wr_en;
         end
      end
   end

   // a write in the read's own cycle is not seen by the array read
   assign byp_hit = byp_vld_ff && (byp_addr_ff == raddr_ff);

   always_comb begin
      if (!valid_ff[raddr_ff]) begin
         rd_data = '0;
      end else if (byp_hit) begin
         rd_data = byp_data_ff;
      end else begin
         rd_data = rd_q_ff;
      end
   end

endmodule

@@ rtl/trigger_step_sequencer_unit.sv @@
// Trigger step sequencer top level: request decode, step state, pattern access and result register.
//
// One item is accepted per clock while the result side is not held by rsp_tready, and every item
// gives exactly one result on rsp_. The accepting edge starts the pattern memory read and loads
// the read stage; the result register loads as the read stage advances. The rate is set by the single pattern
// column memory: each item does at most one read and one write-back of a column, and a
// write-back is forwarded to the item right behind it. Position, run state, clock output and
// dirty flag change at acceptance; the trigger outputs change when the pattern column arrives.
// Clearing the pattern takes effect at once through per-column valid bits, so there is no
// clearing pass after reset.
module trigger_step_sequencer_unit #(
   parameter int NUM_ROWS  = 8,
   parameter int NUM_STEPS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [3:0] column, [6:4] row_index, [7] key_down
   input  logic [tss_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [2:0] req_type
   input  logic [tss_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] clock_level, [8:1] trigger_bits, [12:9] led_level, [16:13] position,
   // [17] running, [18] display_dirty, [23:19] zero
   output logic [tss_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int STEP_W     = $clog2(NUM_STEPS);
   localparam int COL_EXT_W  = (STEP_W > tss_pkg::COL_W) ? STEP_W : tss_pkg::COL_W;
   localparam int POS_EXT_W  = (STEP_W > tss_pkg::POS_W) ? STEP_W : tss_pkg::POS_W;
   localparam int TRIG_EXT_W = (NUM_ROWS > tss_pkg::TRIG_W) ? NUM_ROWS : tss_pkg::TRIG_W;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

   // request fields
   logic [tss_pkg::COL_W-1:0]       req_col;
   logic [tss_pkg::ROW_IDX_W-1:0]   req_row;
   logic                            req_key_down;
   logic [tss_pkg::REQ_TUSER_W-1:0] req_kind;
   logic                            req_fire;
   logic [COL_EXT_W-1:0]            req_col_ext;
   logic                            req_cell_ok;

   // step state
   logic [STEP_W-1:0] pos_ff, pos_in, next_pos;
   logic              running_ff, running_in;
   logic              clock_hold_ff, clock_hold_in;
   logic              dirty_ff, dirty_in;
   logic [NUM_ROWS-1:0] trig_ff, trig_in;

   // read stage
   logic                            b_valid_ff, b_valid_in;
   logic [tss_pkg::REQ_TUSER_W-1:0] b_kind_ff;
   logic [tss_pkg::COL_W-1:0]       b_col_ff;
   logic [tss_pkg::ROW_IDX_W-1:0]   b_row_ff;
   logic                            b_key_ff;
   logic                            b_cell_ok_ff;
   logic [STEP_W-1:0]               b_pos_ff;
   logic                            b_run_ff;
   logic                            b_clock_ff;
   logic                            b_dirty_ff;
   logic                            b_adv;
   logic [COL_EXT_W-1:0]            b_col_ext;
   logic [STEP_W-1:0]               b_addr;

   // memory side
   tss_pkg::tss_mem_ctl_type mem_ctl;
   logic [STEP_W-1:0]        rd_addr;
   logic [NUM_ROWS-1:0]      col_data;
   logic [NUM_ROWS-1:0]      col_shift;
   logic [NUM_ROWS-1:0]      col_toggled;
   logic                     cell_bit;
   logic                     at_pos;
   logic [tss_pkg::LED_W-1:0] led;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tss_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic [TRIG_EXT_W-1:0]          trig_ext;
   logic [POS_EXT_W-1:0]           pos_ext;

   assign req_col      = req_tdata[3:0];
   assign req_row      = req_tdata[6:4];
   assign req_key_down = req_tdata[7];
   assign req_kind     = req_tuser;

   assign b_adv      = b_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !b_valid_ff || b_adv;
   assign req_fire   = req_tvalid && req_tready;

   assign req_col_ext = COL_EXT_W'(req_col);
   assign req_cell_ok = (32'(req_col) < NUM_STEPS) && (32'(req_row) < NUM_ROWS);

   always_comb begin
      if (!running_ff || pos_ff == LAST_STEP) begin
         next_pos = '0;
      end else begin
         next_pos = pos_ff + STEP_W'(1);
      end
   end

   always_comb begin
      pos_in        = pos_ff;
      running_in    = running_ff;
      clock_hold_in = clock_hold_ff;
      dirty_in      = dirty_ff;
      if (req_fire) begin
         case (req_kind)
            tss_pkg::REQ_RISE: begin
               pos_in        = next_pos;
               running_in    = 1'b1;
               dirty_in      = 1'b1;
               clock_hold_in = 1'b1;
            end
            tss_pkg::REQ_FALL: begin
               clock_hold_in = 1'b0;
            end
            tss_pkg::REQ_KEY: begin
               if (req_key_down) begin
                  dirty_in = 1'b1;
               end
            end
            tss_pkg::REQ_STOP: begin
               pos_in     = '0;
               running_in = 1'b0;
               dirty_in   = 1'b1;
            end
            tss_pkg::REQ_CLEAR: begin
               dirty_in = 1'b1;
            end
            tss_pkg::REQ_REFRESH: begin
               dirty_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (req_kind == tss_pkg::REQ_RISE) begin
         rd_addr = next_pos;
      end else if (req_cell_ok) begin
         rd_addr = req_col_ext[STEP_W-1:0];
      end else begin
         rd_addr = '0;
      end
   end

   assign b_valid_in = req_fire ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         running_ff    <= 1'b0;
         clock_hold_ff <= 1'b0;
         dirty_ff      <= 1'b1;
         trig_ff       <= '0;
         b_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         running_ff    <= running_in;
         clock_hold_ff <= clock_hold_in;
         dirty_ff      <= dirty_in;
         trig_ff       <= trig_in;
         b_valid_ff    <= b_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         b_kind_ff    <= req_kind;
         b_col_ff     <= req_col;
         b_row_ff     <= req_row;
         b_key_ff     <= req_key_down;
         b_cell_ok_ff <= req_cell_ok;
         b_pos_ff     <= pos_in;
         b_run_ff     <= running_in;
         b_clock_ff   <= clock_hold_in;
         b_dirty_ff   <= dirty_in;
      end
   end

   assign b_col_ext = COL_EXT_W'(b_col_ff);
   assign b_addr    = b_col_ext[STEP_W-1:0];

   assign mem_ctl.rd_en = req_fire;
   assign mem_ctl.wr_en = b_adv && (b_kind_ff == tss_pkg::REQ_KEY) && b_key_ff && b_cell_ok_ff;
   assign mem_ctl.clr   = b_adv && (b_kind_ff == tss_pkg::REQ_CLEAR);

   tss_pattern_mem #(
      .DEPTH (NUM_STEPS),
      .WIDTH (NUM_ROWS),
      .AW    (STEP_W)
   ) u_pattern_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (b_addr),
      .wr_data (col_toggled),
      .rd_data (col_data)
   );

   assign col_shift   = col_data >> b_row_ff;
   assign cell_bit    = col_shift[0];
   assign col_toggled = col_data ^ (NUM_ROWS'(1) << b_row_ff);
   assign at_pos      = b_run_ff && (b_addr == b_pos_ff);

   always_comb begin
      trig_in = trig_ff;
      if (b_adv) begin
         if (b_kind_ff == tss_pkg::REQ_RISE) begin
            trig_in = col_data;
         end else if (b_kind_ff == tss_pkg::REQ_FALL) begin
            trig_in = '0;
         end
      end
   end

   always_comb begin
      led = tss_pkg::LED_OFF;
      if (b_kind_ff == tss_pkg::REQ_LED && b_cell_ok_ff) begin
         if (cell_bit) begin
            led = at_pos ? tss_pkg::LED_ACTIVE_POSITION : tss_pkg::LED_ACTIVE;
         end else if (at_pos) begin
            led = tss_pkg::LED_POSITION;
         end else if (b_row_ff[2] == b_col_ff[2]) begin
            led = tss_pkg::LED_CHECKER;
         end
      end
   end

   assign trig_ext = TRIG_EXT_W'(trig_in);
   assign pos_ext  = POS_EXT_W'(b_pos_ff);

   assign rsp_valid_in = b_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (b_adv) begin
         rsp_data_ff <= {5'd0, b_dirty_ff, b_run_ff, pos_ext[tss_pkg::POS_W-1:0], led,
                         trig_ext[tss_pkg::TRIG_W-1:0], b_clock_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_pos_needs_run: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != '0) |-> running_ff)
      else $error("step position nonzero while stopped");

   a_stop_only: assert property (@(posedge clock) disable iff (reset)
      ($fell(running_ff) && !$past(reset)) |->
         $past(req_fire && req_kind == tss_pkg::REQ_STOP))
      else $error("sequencer stopped without a stop item");

   a_trig_with_clock: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[8:1] != 8'd0) |-> rsp_data_ff[0])
      else $error("trigger reported with clock low");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (b_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled with room in the pipeline");

endmodule

@@ tb/sv/tb_top.sv @@
// Step sequencer testbench: directed table and random items, checked against table rows or a predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [tss_pkg::REQ_TUSER_W-1:0] REQ_UNUSED = 3'd7;
   localparam int SEQ_STEPS   = 16;
   localparam int RAND_BLOCKS = 16;
   localparam int BLOCK_ITEMS = 100;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [tss_pkg::REQ_TUSER_W-1:0] kind;
      logic [tss_pkg::COL_W-1:0]       col;
      logic [tss_pkg::ROW_IDX_W-1:0]   row;
      logic                            key_down;
   } seq_req_type;

   typedef struct packed {
      logic                       clock_level;
      logic [tss_pkg::TRIG_W-1:0] trigger_bits;
      logic [tss_pkg::LED_W-1:0]  led_level;
      logic [tss_pkg::POS_W-1:0]  position;
      logic                       running;
      logic                       display_dirty;
   } seq_rsp_type;

   typedef struct packed {
      seq_req_type req;
      logic        typed;
      seq_rsp_type rsp;
   } dir_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [tss_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [tss_pkg::REQ_TUSER_W-1:0] req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [tss_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // predictor state
   logic [tss_pkg::TRIG_W-1:0] pat_cols [SEQ_STEPS];
   logic [tss_pkg::POS_W-1:0]  cur_step = '0;
   logic                       seq_running = 1'b0;
   logic                       clk_out = 1'b0;
   logic [tss_pkg::TRIG_W-1:0] trig_out = '0;
   logic                       dirty = 1'b1;

   seq_rsp_type pending_results [$];
   dir_row_type directed_rows [0:20];
   bit          burst_mode = 1'b0;
   int          fail_count = 0;
   int          checked_count = 0;
   int          kind_count [8];
   int          cycle_count = 0;

   trigger_step_sequencer_unit #(
      .NUM_ROWS(8),
      .NUM_STEPS(SEQ_STEPS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("** trigger_step_sequencer_unit: FAILED **");
         $finish;
      end
   end

   function automatic seq_rsp_type sequencer_apply(seq_req_type r);
      seq_rsp_type res;
      logic        at_pos;
      res = '0;
      case (r.kind)
         tss_pkg::REQ_RISE: begin
            cur_step    = seq_running ? cur_step + 1'b1 : '0;
            seq_running = 1'b1;
            dirty       = 1'b1;
            clk_out     = 1'b1;
            trig_out    = pat_cols[cur_step];
         end
         tss_pkg::REQ_FALL: begin
            clk_out  = 1'b0;
            trig_out = '0;
         end
         tss_pkg::REQ_KEY: begin
            if (r.key_down) begin
               pat_cols[r.col][r.row] = ~pat_cols[r.col][r.row];
               dirty = 1'b1;
            end
         end
         tss_pkg::REQ_STOP: begin
            cur_step    = '0;
            seq_running = 1'b0;
            dirty       = 1'b1;
         end
         tss_pkg::REQ_LED: begin
            at_pos = seq_running && (r.col == cur_step);
            if (pat_cols[r.col][r.row])
               res.led_level = at_pos ? tss_pkg::LED_ACTIVE_POSITION : tss_pkg::LED_ACTIVE;
            else if (at_pos)
               res.led_level = tss_pkg::LED_POSITION;
            else if (r.row[2] == r.col[2])
               res.led_level = tss_pkg::LED_CHECKER;
            else
               res.led_level = tss_pkg::LED_OFF;
         end
         tss_pkg::REQ_CLEAR: begin
            foreach (pat_cols[c]) pat_cols[c] = '0;
            dirty = 1'b1;
         end
         tss_pkg::REQ_REFRESH: dirty = 1'b0;
         default: ;
      endcase
      res.clock_level   = clk_out;
      res.trigger_bits  = trig_out;
      res.position      = cur_step;
      res.running       = seq_running;
      res.display_dirty = dirty;
      return res;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic push_item(seq_req_type it, logic use_typed, seq_rsp_type typed_rsp);
      seq_rsp_type predicted;
      int unsigned gap;
      gap = burst_mode ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.key_down, it.row, it.col};
      req_tuser  <= it.kind;
      do @(posedge clock); while (!req_tready);
      predicted = sequencer_apply(it);
      pending_results.push_back(use_typed ? typed_rsp : predicted);
      kind_count[it.kind]++;
   endtask

   // result side: random stalls, in-order compare
   initial begin
      seq_rsp_type want;
      seq_rsp_type got;
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = {rsp_tdata[0], rsp_tdata[8:1], rsp_tdata[12:9], rsp_tdata[16:13],
                rsp_tdata[17], rsp_tdata[18]};
         if (pending_results.size() == 0) begin
            $error("result with no expectation pending: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            check_field("clock_level", 32'(want.clock_level), 32'(got.clock_level));
            check_field("trigger_bits", 32'(want.trigger_bits), 32'(got.trigger_bits));
            check_field("led_level", 32'(want.led_level), 32'(got.led_level));
            check_field("position", 32'(want.position), 32'(got.position));
            check_field("running", 32'(want.running), 32'(got.running));
            check_field("display_dirty", 32'(want.display_dirty), 32'(got.display_dirty));
            check_field("pad", 32'(0), 32'(rsp_tdata[23:19]));
         end
      end
   end

   initial begin
      seq_req_type it;
      int          pick;
      foreach (pat_cols[c]) pat_cols[c] = '0;
      foreach (kind_count[k]) kind_count[k] = 0;
      directed_rows = '{
         '{'{tss_pkg::REQ_REFRESH, 4'd0, 3'd0, 1'b0}, 1'b1,
           '{1'b0, 8'h00, tss_pkg::LED_OFF, 4'd0, 1'b0, 1'b0}},
         '{'{tss_pkg::REQ_LED, 4'd0, 3'd0, 1'b0}, 1'b1,
           '{1'b0, 8'h00, tss_pkg::LED_CHECKER, 4'd0, 1'b0, 1'b0}},
         '{'{tss_pkg::REQ_LED, 4'd15, 3'd7, 1'b0}, 1'b1,
           '{1'b0, 8'h00, tss_pkg::LED_CHECKER, 4'd0, 1'b0, 1'b0}},
         '{'{tss_pkg::REQ_LED, 4'd4, 3'd0, 1'b0}, 1'b1,
           '{1'b0, 8'h00, tss_pkg::LED_OFF, 4'd0, 1'b0, 1'b0}},
         // key release: nothing changes
         '{'{tss_pkg::REQ_KEY, 4'd3, 3'd5, 1'b0}, 1'b1,
           '{1'b0, 8'h00, tss_pkg::LED_OFF, 4'd0, 1'b0, 1'b0}},
         '{'{tss_pkg::REQ_KEY, 4'd0, 3'd0, 1'b1}, 1'b1,
           '{1'b0, 8'h00, tss_pkg::LED_OFF, 4'd0, 1'b0, 1'b1}},
         '{'{tss_pkg::REQ_KEY,     4'd15, 3'd7, 1'b1}, 1'b0, seq_rsp_type'('0)},
         '{'{tss_pkg::REQ_KEY,     4'd0,  3'd7, 1'b1}, 1'b0, seq_rsp_type'('0)},
         '{'{tss_pkg::REQ_RISE,    4'd9,  3'd2, 1'b0}, 1'b0, seq_rsp_type'('0)},
         '{'{tss_pkg::REQ_LED,     4'd0,  3'd0, 1'b0}, 1'b0, seq_rsp_type'('0)},
         '{'{tss_pkg::REQ_LED,     4'd0,  3'd1, 1'b0}, 1'b0, seq_rsp_type'('0)},
         '{'{tss_pkg::REQ_LED,     4'd15, 3'd7, 1'b0}, 1'b0, seq_rsp_type'('0)},
         '{'{tss_pkg::REQ_FALL,    4'd15, 3'd7, 1'b1}, 1'b0, seq_rsp_type'('0)},
         '{'{tss_pkg::REQ_RISE,    4'd0,  3'd0, 1'b0}, 1'b0, seq_rsp_type'('0)},
         '{'{tss_pkg::REQ_LED,     4'd1,  3'd0, 1'b0}, 1'b0, seq_rsp_type'('0)},
         '{'{tss_pkg::REQ_STOP,    4'd0,  3'd0, 1'b0}, 1'b0, seq_rsp_type'('0)},
         // stopped: no position column
         '{'{tss_pkg::REQ_LED,     4'd0,  3'd0, 1'b0}, 1'b0, seq_rsp_type'('0)},
         '{'{REQ_UNUSED,           4'd15, 3'd7, 1'b1}, 1'b0, seq_rsp_type'('0)},
         '{'{tss_pkg::REQ_CLEAR,   4'd5,  3'd3, 1'b1}, 1'b0, seq_rsp_type'('0)},
         '{'{tss_pkg::REQ_REFRESH, 4'd15, 3'd7, 1'b1}, 1'b0, seq_rsp_type'('0)},
         '{'{tss_pkg::REQ_RISE,    4'd0,  3'd0, 1'b0}, 1'b0, seq_rsp_type'('0)}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         push_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
         burst_mode = (blk == 0) || ($urandom_range(0, 3) == 0);
         if (blk == RAND_BLOCKS / 2) begin
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            it.col      = 4'($urandom_range(0, 15));
            it.row      = 3'($urandom_range(0, 7));
            it.key_down = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 18)
               it.kind = tss_pkg::REQ_RISE;
            else if (pick < 36)
               it.kind = tss_pkg::REQ_FALL;
            else if (pick < 58) begin
               it.kind     = tss_pkg::REQ_KEY;
               it.key_down = ($urandom_range(0, 4) != 0);
            end else if (pick < 78) begin
               it.kind = tss_pkg::REQ_LED;
               if ($urandom_range(0, 1) == 0) it.col = cur_step;
            end else if (pick < 82)
               it.kind = tss_pkg::REQ_STOP;
            else if (pick < 85)
               it.kind = tss_pkg::REQ_CLEAR;
            else if (pick < 95)
               it.kind = tss_pkg::REQ_REFRESH;
            else
               it.kind = REQ_UNUSED;
            push_item(it, 1'b0, seq_rsp_type'('0));
         end
      end
      burst_mode = 1'b0;
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d items: %0d rises, %0d falls, %0d keys, %0d LED reads, %0d stops,",
               RAND_BLOCKS * BLOCK_ITEMS + $size(directed_rows),
               kind_count[tss_pkg::REQ_RISE], kind_count[tss_pkg::REQ_FALL],
               kind_count[tss_pkg::REQ_KEY], kind_count[tss_pkg::REQ_LED],
               kind_count[tss_pkg::REQ_STOP]);
      $display("%0d clears, %0d refreshes, %0d unused codes; %0d results compared, %0d errors.",
               kind_count[tss_pkg::REQ_CLEAR], kind_count[tss_pkg::REQ_REFRESH],
               kind_count[REQ_UNUSED], checked_count, fail_count);
      if (fail_count == 0)
         $display("** trigger_step_sequencer_unit: PASSED **");
      else
         $display("** trigger_step_sequencer_unit: FAILED **");
      $finish;
   end

endmodule
